### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the text display controller.
// Each macro takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tdc_pkg.sv
// Package of the text display controller: codes, constants and shared types.
// No dependencies; used by every module of the block.
`default_nettype none

package tdc_pkg;

    localparam int MAX_LINES_DEF = 4;
    localparam int ROW_STRIDE    = 128;
    localparam int GLYPH_WORDS   = 512;
    localparam int GLYPH_AW      = $clog2(GLYPH_WORDS);

    localparam int IN_W  = 24;
    localparam int OUT_W = 128;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_QUERY     = 3'd1;
    localparam logic [2:0] ACT_CONTROL   = 3'd2;
    localparam logic [2:0] ACT_SET_ADDR  = 3'd3;
    localparam logic [2:0] ACT_RESET_CTL = 3'd4;
    localparam logic [2:0] ACT_WRITE     = 3'd5;
    localparam logic [2:0] ACT_FULL_RST  = 3'd6;
    localparam logic [2:0] ACT_UNSUP     = 3'd7;

    localparam logic [1:0] WK_NONE  = 2'd0;
    localparam logic [1:0] WK_TEXT  = 2'd1;
    localparam logic [1:0] WK_GLYPH = 2'd2;

    localparam logic [1:0] CLR_NONE = 2'd0;
    localparam logic [1:0] CLR_TEXT = 2'd1;
    localparam logic [1:0] CLR_ALL  = 2'd2;

    localparam logic [0:0] CFG_LINE_COUNT   = 1'd0;
    localparam logic [0:0] CFG_COLUMN_COUNT = 1'd1;

    localparam logic [2:0]  LINE_COUNT_RST   = 3'd4;
    localparam logic [6:0]  COLUMN_COUNT_RST = 7'd124;
    localparam logic [7:0]  SPACE_CHAR       = 8'd32;
    localparam logic [15:0] CURSOR_LIMIT     = 16'h0400;

    localparam logic [15:0] ID_WORD0     = 16'he4ff;
    localparam logic [15:0] ID_WORD1     = 16'hed73;
    localparam logic [15:0] VERSION_BASE = 16'h0500;
    localparam logic [15:0] ID_WORD3     = 16'h5742;
    localparam logic [15:0] ID_WORD4     = 16'h59ea;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic clr_step;
        logic clr_init;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_need;
        logic clr_last;
    } sts_t;

    function automatic logic [15:0] version_word(input logic [2:0] lines);
        logic [2:0] lm1;
        lm1 = lines - 3'd1;
        return VERSION_BASE | {8'd0, lm1, 4'd0, lines[2]};
    endfunction

endpackage

`default_nettype wire

### hdl/text_display_controller_core.sv
// Top level of the text display controller: controller and datapath joined by command/status.
// Depends on tdc_pkg, tdc_ctrl, tdc_datapath and assert_macros.svh.
//
//   Channel   Direction  Ports                       Contents
//   s_        in         s_tvalid/s_tready/s_tdata   one bus request
//   m_        out        m_tvalid/m_tready/m_tdata   one status result per request
//   cfg_      in         cfg_we/cfg_addr/cfg_wdata   line and column counts
//
// From acceptance to the next acceptance, with the result taken at once, a request goes
// through the steps accept, execute and load the output register.
// A text or full clear adds a sweep over the stores, one glyph store entry per cycle.
// After reset a clearing pass runs with s_tready low.
// A stalled result holds the block in its final step until the output register frees.
`default_nettype none
`include "assert_macros.svh"

module text_display_controller_core #(
    parameter int MAX_LINES = tdc_pkg::MAX_LINES_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // s_tdata: action [2:0], value [18:3], zero pad [23:19]
    input  wire logic [tdc_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // m_tdata: reply_word0 [15:0], reply_word1 [31:16], reply_word2 [47:32],
    // reply_word3 [63:48], reply_word4 [79:64], control_bits [84:80],
    // backlight_on [85], cursor [95:86], write_kind [97:96], write_index [106:98],
    // write_value [122:107], cleared [124:123], zero pad [127:125]
    output logic [tdc_pkg::OUT_W-1:0]      m_tdata,
    input  wire logic                      cfg_we,
    input  wire logic [0:0]                cfg_addr,
    input  wire logic [6:0]                cfg_wdata
);

    tdc_pkg::cmd_t cmd;
    tdc_pkg::sts_t sts;

    tdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tdc_datapath #(
        .MAX_LINES (MAX_LINES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

    `ASSERT_NEXT(a_one_request, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "a second request was taken while one was in progress")
    `ASSERT_SAME(a_no_write_zero, aclk, aresetn,
        m_tvalid && (m_tdata[97:96] == tdc_pkg::WK_NONE),
        (m_tdata[106:98] == 9'd0) && (m_tdata[122:107] == 16'd0),
        "write index or value set without a store write")
    `ASSERT_SAME(a_clear_no_write, aclk, aresetn,
        m_tvalid && (m_tdata[124:123] != tdc_pkg::CLR_NONE),
        m_tdata[97:96] == tdc_pkg::WK_NONE,
        "a clearing request reported a store write")

endmodule

`default_nettype wire

### hdl/tdc_ctrl.sv
// Controller of the text display controller: sequences request, store clear and result.
// Depends on tdc_pkg; drives the datapath through tdc_pkg::cmd_t.
`default_nettype none

module tdc_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire tdc_pkg::sts_t sts,
    output tdc_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_INIT: begin
                cmd.clr_step = 1'b1;
                cmd.clr_init = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.clr_need ? ST_CLEAR : ST_DONE;
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

### hdl/tdc_datapath.sv
// Datapath of the text display controller: registers, cursor logic, stores and result.
// Depends on tdc_pkg; commanded by tdc_ctrl.
`default_nettype none

module tdc_datapath #(
    parameter int MAX_LINES = tdc_pkg::MAX_LINES_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [tdc_pkg::IN_W-1:0] s_tdata,
    input  wire logic                     cfg_we,
    input  wire logic [0:0]               cfg_addr,
    input  wire logic [6:0]               cfg_wdata,
    input  wire tdc_pkg::cmd_t            cmd,
    output tdc_pkg::sts_t                 sts,
    output logic [tdc_pkg::OUT_W-1:0]     m_tdata
);

    localparam int TEXT_WORDS = MAX_LINES * tdc_pkg::ROW_STRIDE;
    localparam int TEXT_AW    = $clog2(TEXT_WORDS);

    logic [2:0]  line_count_reg;
    logic [6:0]  column_count_reg;
    logic [4:0]  control_reg, control_next;
    logic [9:0]  cursor_reg, cursor_next;
    logic [2:0]  act_reg;
    logic [15:0] val_reg;
    logic        query_reg, query_next;
    logic [1:0]  wkind_reg, wkind_next;
    logic [8:0]  windex_reg, windex_next;
    logic [15:0] wval_reg, wval_next;
    logic [1:0]  cleared_reg, cleared_next;
    logic [tdc_pkg::GLYPH_AW-1:0] clr_cnt_reg;
    logic [tdc_pkg::OUT_W-1:0]    out_reg;

    logic [7:0]  text_mem [TEXT_WORDS];
    logic [15:0] glyph_mem [tdc_pkg::GLYPH_WORDS];

    logic [2:0]  eff_lines;
    logic [6:0]  eff_cols;
    logic [2:0]  line3, nl;
    logic [6:0]  col, nc;
    logic        text_wr, glyph_wr;
    logic        clr_text, clr_glyph;
    logic [7:0]  clr_fill;
    logic [15:0] rep0, rep1, rep2, rep3, rep4;

    always_comb begin
        if (line_count_reg == 3'd0) begin
            eff_lines = 3'd1;
        end else if (line_count_reg > 3'(MAX_LINES)) begin
            eff_lines = 3'(MAX_LINES);
        end else begin
            eff_lines = line_count_reg;
        end
        eff_cols = {column_count_reg[6:2], 2'b00};
        if (eff_cols == 7'd0) begin
            eff_cols = 7'd4;
        end
    end

    always_comb begin
        control_next = control_reg;
        cursor_next  = cursor_reg;
        query_next   = 1'b0;
        wkind_next   = tdc_pkg::WK_NONE;
        windex_next  = 9'd0;
        wval_next    = 16'd0;
        cleared_next = tdc_pkg::CLR_NONE;
        text_wr      = 1'b0;
        glyph_wr     = 1'b0;
        line3        = {1'b0, cursor_reg[8:7]};
        col          = cursor_reg[6:0];
        nl           = line3 + 3'd1;
        nc           = col + 7'd1;
        unique case (act_reg)
            tdc_pkg::ACT_QUERY: begin
                query_next = 1'b1;
            end
            tdc_pkg::ACT_CONTROL: begin
                control_next = val_reg[4:0];
            end
            tdc_pkg::ACT_SET_ADDR: begin
                if (val_reg < tdc_pkg::CURSOR_LIMIT) begin
                    cursor_next = val_reg[9:0];
                end
            end
            tdc_pkg::ACT_RESET_CTL: begin
                if (val_reg[0]) begin
                    cleared_next = tdc_pkg::CLR_TEXT;
                end
                if (val_reg[1]) begin
                    cursor_next = 10'd0;
                end
            end
            tdc_pkg::ACT_WRITE: begin
                if (cursor_reg[9]) begin
                    glyph_wr    = 1'b1;
                    wkind_next  = tdc_pkg::WK_GLYPH;
                    windex_next = cursor_reg[8:0];
                    wval_next   = val_reg;
                    cursor_next = cursor_reg + 10'd1;
                end else if (col >= eff_cols) begin
                    cursor_next = (nl >= eff_lines) ? 10'd0 : {1'b0, nl[1:0], col};
                end else if (line3 >= eff_lines) begin
                    cursor_next = 10'd0;
                end else begin
                    text_wr     = 1'b1;
                    wkind_next  = tdc_pkg::WK_TEXT;
                    windex_next = cursor_reg[8:0];
                    wval_next   = {8'd0, val_reg[7:0]};
                    if (nc >= eff_cols) begin
                        cursor_next = (nl >= eff_lines) ? 10'd0 : {1'b0, nl[1:0], 7'd0};
                    end else begin
                        cursor_next = {1'b0, cursor_reg[8:7], nc};
                    end
                end
            end
            tdc_pkg::ACT_FULL_RST: begin
                cleared_next = tdc_pkg::CLR_ALL;
            end
            tdc_pkg::ACT_NONE, tdc_pkg::ACT_UNSUP: begin
            end
        endcase
    end

    assign clr_text  = cmd.clr_init || (cleared_reg != tdc_pkg::CLR_NONE);
    assign clr_glyph = cmd.clr_init || (cleared_reg == tdc_pkg::CLR_ALL);
    assign clr_fill  = (cmd.clr_init || (cleared_reg == tdc_pkg::CLR_TEXT)) ?
                       tdc_pkg::SPACE_CHAR : 8'd0;

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            if (clr_text && (int'(clr_cnt_reg) < TEXT_WORDS)) begin
                text_mem[clr_cnt_reg[TEXT_AW-1:0]] <= clr_fill;
            end
        end else if (cmd.exec && text_wr) begin
            text_mem[cursor_reg[TEXT_AW-1:0]] <= val_reg[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            if (clr_glyph) begin
                glyph_mem[clr_cnt_reg] <= 16'd0;
            end
        end else if (cmd.exec && glyph_wr) begin
            glyph_mem[cursor_reg[8:0]] <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg   <= tdc_pkg::LINE_COUNT_RST;
            column_count_reg <= tdc_pkg::COLUMN_COUNT_RST;
            control_reg      <= 5'd0;
            cursor_reg       <= 10'd0;
            clr_cnt_reg      <= '0;
            cleared_reg      <= tdc_pkg::CLR_NONE;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    tdc_pkg::CFG_LINE_COUNT:   line_count_reg   <= cfg_wdata[2:0];
                    tdc_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_wdata;
                endcase
            end
            if (cmd.exec) begin
                control_reg <= control_next;
                cursor_reg  <= cursor_next;
                cleared_reg <= cleared_next;
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + tdc_pkg::GLYPH_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg <= s_tdata[2:0];
            val_reg <= s_tdata[18:3];
        end
        if (cmd.exec) begin
            query_reg  <= query_next;
            wkind_reg  <= wkind_next;
            windex_reg <= windex_next;
            wval_reg   <= wval_next;
        end
        if (cmd.load_out) begin
            out_reg <= {3'd0, cleared_reg, wval_reg, windex_reg, wkind_reg, cursor_reg,
                        &control_reg[1:0], control_reg, rep4, rep3, rep2, rep1, rep0};
        end
    end

    assign rep0 = query_reg ? tdc_pkg::ID_WORD0 : 16'd0;
    assign rep1 = query_reg ? tdc_pkg::ID_WORD1 : 16'd0;
    assign rep2 = query_reg ? tdc_pkg::version_word(eff_lines) : 16'd0;
    assign rep3 = query_reg ? tdc_pkg::ID_WORD3 : 16'd0;
    assign rep4 = query_reg ? tdc_pkg::ID_WORD4 : 16'd0;

    assign sts.clr_need = ((act_reg == tdc_pkg::ACT_RESET_CTL) && val_reg[0]) ||
                          (act_reg == tdc_pkg::ACT_FULL_RST);
    assign sts.clr_last = (clr_cnt_reg == tdc_pkg::GLYPH_AW'(tdc_pkg::GLYPH_WORDS - 1));
    assign m_tdata      = out_reg;

endmodule

`default_nettype wire

### tb/text_display_controller_core_test.sv
// Self-checking testbench for text_display_controller_core: directed requests, then random
// request sequences under several line and column settings, random stalls on both sides
// but in the last setting. Depends on tdc_pkg and the RTL of the block; reads no files.
module text_display_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tdc_pkg::*;

    localparam int LIMIT = 1_500_000;
    localparam int TEXT_LINES = 4;
    localparam int PHASE_ITEMS = 230;
    localparam int PHASES = 8;
    localparam logic [15:0] QUERY_ID0 = 16'he4ff;
    localparam logic [15:0] QUERY_ID1 = 16'hed73;
    localparam logic [15:0] QUERY_ID3 = 16'h5742;
    localparam logic [15:0] QUERY_ID4 = 16'h59ea;
    localparam logic [2:0] PHASE_LINES [PHASES] =
        '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4, 3'd6};
    localparam logic [6:0] PHASE_COLS [PHASES] =
        '{7'd4, 7'd0, 7'd127, 7'd3, 7'd61, 7'd18, 7'd124, 7'd90};

    typedef struct packed {
        logic [2:0]  pad;
        logic [1:0]  cleared;
        logic [15:0] wvalue;
        logic [8:0]  windex;
        logic [1:0]  wkind;
        logic [9:0]  cursor;
        logic        backlight;
        logic [4:0]  ctrl;
        logic [15:0] word4;
        logic [15:0] word3;
        logic [15:0] word2;
        logic [15:0] word1;
        logic [15:0] word0;
    } display_status_t;

    typedef struct {
        logic [2:0]      act;
        logic [15:0]     val;
        bit              typed;
        display_status_t want;
    } request_row_t;

    logic             aclk;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we = 1'b0;
    logic [0:0]       cfg_addr = CFG_LINE_COUNT;
    logic [6:0]       cfg_wdata = '0;

    logic [2:0] line_cfg = 3'd4;
    logic [6:0] col_cfg = 7'd124;
    logic [4:0] control_q = '0;
    logic [9:0] cursor_q = '0;

    display_status_t status_due[$];
    request_row_t    directed_rows[$];
    int              error_count = 0;
    int              cycle_count = 0;
    bit              quiet = 1'b0;

    text_display_controller_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int usable_lines();
        int n;
        n = int'(line_cfg);
        if (n == 0) n = 1;
        if (n > TEXT_LINES) n = TEXT_LINES;
        return n;
    endfunction

    function automatic int usable_columns();
        int n;
        n = int'(col_cfg) & ~3;
        if (n < 4) n = 4;
        return n;
    endfunction

    function automatic display_status_t status_of(
        input logic [15:0] w0, input logic [15:0] w1, input logic [15:0] w2,
        input logic [15:0] w3, input logic [15:0] w4, input logic [4:0] ctrl,
        input logic bl, input logic [9:0] cur, input logic [1:0] kind,
        input logic [8:0] idx, input logic [15:0] wval, input logic [1:0] clr);
        display_status_t r;
        r = '0;
        r.word0 = w0;
        r.word1 = w1;
        r.word2 = w2;
        r.word3 = w3;
        r.word4 = w4;
        r.ctrl = ctrl;
        r.backlight = bl;
        r.cursor = cur;
        r.wkind = kind;
        r.windex = idx;
        r.wvalue = wval;
        r.cleared = clr;
        return r;
    endfunction

    function automatic display_status_t predict_status(input logic [2:0] act,
                                                       input logic [15:0] val);
        display_status_t r;
        int lines, cols, line, col;
        r = '0;
        lines = usable_lines();
        cols = usable_columns();
        case (act)
            ACT_QUERY: begin
                r.word0 = QUERY_ID0;
                r.word1 = QUERY_ID1;
                r.word2 = 16'h0500 | 16'((lines - 1) << 5) | 16'((lines >> 2) & 31);
                r.word3 = QUERY_ID3;
                r.word4 = QUERY_ID4;
            end
            ACT_CONTROL: control_q = val[4:0];
            ACT_SET_ADDR: begin
                if (val < 16'h0400) cursor_q = val[9:0];
            end
            ACT_RESET_CTL: begin
                if (val[0]) r.cleared = CLR_TEXT;
                if (val[1]) cursor_q = '0;
            end
            ACT_WRITE: begin
                if (cursor_q >= 10'h200) begin
                    r.wkind = WK_GLYPH;
                    r.windex = cursor_q[8:0];
                    r.wvalue = val;
                    cursor_q = cursor_q + 10'd1;
                end else begin
                    line = int'(cursor_q[9:7]);
                    col = int'(cursor_q[6:0]);
                    if (col >= cols) begin
                        line++;
                        if (line >= lines) begin
                            line = 0;
                            col = 0;
                        end
                    end else if (line >= lines) begin
                        line = 0;
                        col = 0;
                    end else begin
                        r.wkind = WK_TEXT;
                        r.windex = 9'(line * 128 + col);
                        r.wvalue = {8'h00, val[7:0]};
                        col++;
                        if (col >= cols) begin
                            col = 0;
                            line++;
                            if (line >= lines) line = 0;
                        end
                    end
                    cursor_q = 10'((line << 7) | col);
                end
            end
            ACT_FULL_RST: r.cleared = CLR_ALL;
            default: ;
        endcase
        r.ctrl = control_q;
        r.backlight = &control_q[1:0];
        r.cursor = cursor_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function automatic void compare_status(input display_status_t want,
                                           input display_status_t got);
        check_field("reply_word0", want.word0, got.word0);
        check_field("reply_word1", want.word1, got.word1);
        check_field("reply_word2", want.word2, got.word2);
        check_field("reply_word3", want.word3, got.word3);
        check_field("reply_word4", want.word4, got.word4);
        check_field("control_bits", 16'(want.ctrl), 16'(got.ctrl));
        check_field("backlight_on", 16'(want.backlight), 16'(got.backlight));
        check_field("cursor", 16'(want.cursor), 16'(got.cursor));
        check_field("write_kind", 16'(want.wkind), 16'(got.wkind));
        check_field("write_index", 16'(want.windex), 16'(got.windex));
        check_field("write_value", want.wvalue, got.wvalue);
        check_field("cleared", 16'(want.cleared), 16'(got.cleared));
        check_field("pad", 16'(want.pad), 16'(got.pad));
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                compare_status(status_due.pop_front(), display_status_t'(m_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("text_display_controller_core: mismatch");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [2:0] act, input logic [15:0] val,
                                input bit typed = 1'b0, input display_status_t want = '0);
        display_status_t predicted;
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, val, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_status(act, val);
        status_due.push_back(typed ? want : predicted);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= IN_W'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [2:0] lines_raw, input logic [6:0] cols_raw);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_LINE_COUNT;
        cfg_wdata <= {4'($urandom), lines_raw};
        @(posedge aclk);
        cfg_addr <= CFG_COLUMN_COUNT;
        cfg_wdata <= cols_raw;
        @(posedge aclk);
        cfg_we <= 1'b0;
        line_cfg = lines_raw;
        col_cfg = cols_raw;
    endtask

    function automatic logic [15:0] pick_address();
        int lines, cols, line;
        lines = usable_lines();
        cols = usable_columns();
        line = $urandom_range(0, 3);
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 1023));
            1: return 16'(line * 128 + cols - 1 - $urandom_range(0, 2));
            2: return 16'(line * 128 + $urandom_range(cols, 127));
            3: return 16'($urandom_range(lines, 3) * 128 + $urandom_range(0, 127));
            4: return 16'($urandom_range(16'h0200, 16'h03ff));
            5: return 16'(16'h03f8 + $urandom_range(0, 7));
            6: return 16'($urandom_range(16'h0400, 16'hffff));
            default: return 16'(line * 128 + $urandom_range(0, cols - 1));
        endcase
    endfunction

    task automatic run_phase(input int count);
        int sent, n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 6) begin
                send_request(ACT_SET_ADDR, pick_address());
                n = $urandom_range(1, 12);
                repeat (n) send_request(ACT_WRITE, 16'($urandom));
                sent += n + 1;
            end else begin
                send_request(3'($urandom_range(0, 7)), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        directed_rows.push_back('{ACT_QUERY, 16'h0000, 1'b1,
            status_of(16'he4ff, 16'hed73, 16'h0561, 16'h5742, 16'h59ea,
                      5'd0, 1'b0, 10'd0, WK_NONE, 9'd0, 16'h0000, CLR_NONE)});
        directed_rows.push_back('{ACT_NONE, 16'hffff, 1'b1,
            status_of(16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                      5'd0, 1'b0, 10'd0, WK_NONE, 9'd0, 16'h0000, CLR_NONE)});
        directed_rows.push_back('{ACT_UNSUP, 16'hffff, 1'b1,
            status_of(16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                      5'd0, 1'b0, 10'd0, WK_NONE, 9'd0, 16'h0000, CLR_NONE)});
        directed_rows.push_back('{ACT_CONTROL, 16'hffff, 1'b1,
            status_of(16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                      5'd31, 1'b1, 10'd0, WK_NONE, 9'd0, 16'h0000, CLR_NONE)});
        directed_rows.push_back('{ACT_WRITE, 16'h00a5, 1'b1,
            status_of(16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                      5'd31, 1'b1, 10'd1, WK_TEXT, 9'd0, 16'h00a5, CLR_NONE)});
        directed_rows.push_back('{ACT_CONTROL, 16'h0002, 1'b0, '0});
        directed_rows.push_back('{ACT_CONTROL, 16'h0001, 1'b0, '0});
        directed_rows.push_back('{ACT_SET_ADDR, 16'h007b, 1'b0, '0});
        directed_rows.push_back('{ACT_WRITE, 16'hffff, 1'b0, '0});
        directed_rows.push_back('{ACT_SET_ADDR, 16'h017c, 1'b0, '0});
        directed_rows.push_back('{ACT_WRITE, 16'h5a5a, 1'b0, '0});
        directed_rows.push_back('{ACT_WRITE, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{ACT_SET_ADDR, 16'h01fb, 1'b0, '0});
        directed_rows.push_back('{ACT_WRITE, 16'h0080, 1'b0, '0});
        directed_rows.push_back('{ACT_SET_ADDR, 16'h0200, 1'b0, '0});
        directed_rows.push_back('{ACT_WRITE, 16'h1234, 1'b0, '0});
        directed_rows.push_back('{ACT_SET_ADDR, 16'h03ff, 1'b0, '0});
        directed_rows.push_back('{ACT_WRITE, 16'hffff, 1'b0, '0});
        directed_rows.push_back('{ACT_SET_ADDR, 16'h0400, 1'b0, '0});
        directed_rows.push_back('{ACT_SET_ADDR, 16'h03ff, 1'b0, '0});
        directed_rows.push_back('{ACT_RESET_CTL, 16'h0002, 1'b0, '0});
        directed_rows.push_back('{ACT_RESET_CTL, 16'h0001, 1'b0, '0});
        directed_rows.push_back('{ACT_RESET_CTL, 16'hfffc, 1'b0, '0});
        directed_rows.push_back('{ACT_FULL_RST, 16'hffff, 1'b0, '0});
        directed_rows.push_back('{ACT_SET_ADDR, 16'h0155, 1'b0, '0});
        directed_rows.push_back('{ACT_RESET_CTL, 16'h0003, 1'b0, '0});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].act, directed_rows[i].val,
                         directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < PHASES; p++) begin
            drain_results(8);
            set_geometry(PHASE_LINES[p], PHASE_COLS[p]);
            quiet = (p == PHASES - 1);
            run_phase(PHASE_ITEMS);
        end

        drain_results(20);
        if (error_count == 0) begin
            $display("text_display_controller_core: match");
        end else begin
            $display("text_display_controller_core: mismatch");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/tdc_pkg.sv
hdl/tdc_ctrl.sv
hdl/tdc_datapath.sv
hdl/text_display_controller_core.sv
tb/text_display_controller_core_test.sv
